// ----- rtl/core/mtsed_pkg.sv -----
// Shared types and constants for the multitouch slot event decoder.
// No dependencies; imported by the decoder core and its port checker.
`timescale 1ns / 1ps
`default_nettype none

package mtsed_pkg;

    // Slot table geometry
    localparam int NUM_SLOTS  = 5;
    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int FINGER_W   = 4;

    // Field widths
    localparam int TYPE_W  = 16;
    localparam int CODE_W  = 16;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 12;
    localparam int SIZE_W  = 13;

    localparam int S_TDATA_W = 48;   // code, value
    localparam int S_TUSER_W = 16;   // event type
    localparam int M_TDATA_W = 32;   // x, y, finger, zero fill
    localparam int M_TUSER_W = 2;    // touch status

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Event types and codes
    localparam logic [TYPE_W-1:0] TYPE_SYN    = 16'h0000;
    localparam logic [TYPE_W-1:0] TYPE_ABS    = 16'h0003;
    localparam logic [CODE_W-1:0] CODE_REPORT = 16'h0000;
    localparam logic [CODE_W-1:0] CODE_SLOT   = 16'h002f;
    localparam logic [CODE_W-1:0] CODE_TRACK  = 16'h0039;
    localparam logic [CODE_W-1:0] CODE_X      = 16'h0035;
    localparam logic [CODE_W-1:0] CODE_Y      = 16'h0036;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

    localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RST  = 13'd800;
    localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_PRESS   = 2'd1,
        ST_MOVE    = 2'd2,
        ST_RELEASE = 2'd3
    } touch_status_t;

    // Saturate a raw position to 0..4095, scale by size/4096, saturate again.
    function automatic logic [POS_W-1:0] scale_pos(
        input logic signed [VALUE_W-1:0] v,
        input logic [SIZE_W-1:0]         size
    );
        logic [POS_W-1:0]        c;
        logic [POS_W+SIZE_W-1:0] prod;
        logic [SIZE_W-1:0]       r;
        if (v[VALUE_W-1]) begin
            c = '0;
        end else if (|v[VALUE_W-2:POS_W]) begin
            c = '1;
        end else begin
            c = v[POS_W-1:0];
        end
        prod = (POS_W+SIZE_W)'(c) * (POS_W+SIZE_W)'(size);
        r    = prod[POS_W+SIZE_W-1:POS_W];
        return r[SIZE_W-1] ? '1 : r[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/multitouch_slot_event_decoder_unit.sv -----
// Multitouch slot event decoder top level: slot table, scaling and stream ports.
// Depends on mtsed_pkg for types, codes and the position scaling function.
`timescale 1ns / 1ps
`default_nettype none

// Decodes multitouch type-B input events into finger reports. Every accepted
// event word gives exactly one result word, in order; touch status none
// carries all-zero coordinates and finger. A word reaches the master side
// through the input register and then the result register, and the
// block takes one event every cycle as long as the result side keeps up: the
// slot table is read, scaled and written back in the single stage between the
// two registers. Screen width and height are written through the cfg port,
// which is always ready; write them only while no event is in flight.
module multitouch_slot_event_decoder_unit
    import mtsed_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // event stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [15:0] event_code, [47:16] event_value
    input  wire logic [S_TUSER_W-1:0]  s_tuser,   // [15:0] event_type
    // report stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [11:0] x_coord, [23:12] y_coord,
                                                  // [27:24] finger, [31:28] zero
    output logic [M_TUSER_W-1:0]       m_tuser,   // [1:0] touch_status
    // configuration
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [SIZE_W-1:0] width_reg, height_reg;

    logic                      in_valid_reg;
    logic [TYPE_W-1:0]         in_type_reg;
    logic [CODE_W-1:0]         in_code_reg;
    logic signed [VALUE_W-1:0] in_value_reg;

    logic                  out_valid_reg;
    touch_status_t         out_status_reg;
    logic [POS_W-1:0]      out_x_reg, out_y_reg;
    logic [FINGER_W-1:0]   out_finger_reg;

    logic [POS_W-1:0]      slot_x_reg  [NUM_SLOTS];
    logic [POS_W-1:0]      slot_y_reg  [NUM_SLOTS];
    touch_status_t         slot_pend_reg [NUM_SLOTS];
    logic [SLOT_IDX_W-1:0] cur_slot_reg;

    logic out_free, advance;

    // decode results
    touch_status_t         res_status;
    logic                  res_emit;
    logic                  pend_wr;
    touch_status_t         pend_next;
    logic                  x_wr, y_wr, slot_wr;
    logic [POS_W-1:0]      x_next, y_next;
    logic [SLOT_IDX_W-1:0] cur_slot_next;
    logic                  is_abs, slot_ok, not_press;
    touch_status_t         cur_pend;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(M_TDATA_W-2*POS_W-FINGER_W){1'b0}},
                       out_finger_reg, out_y_reg, out_x_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SCREEN_WIDTH_RST;
            height_reg <= SCREEN_HEIGHT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                CFG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_type_reg  <= s_tuser[TYPE_W-1:0];
            in_code_reg  <= s_tdata[CODE_W-1:0];
            in_value_reg <= s_tdata[CODE_W+VALUE_W-1:CODE_W];
        end
    end

    assign is_abs    = (in_type_reg == TYPE_ABS);
    assign slot_ok   = !in_value_reg[VALUE_W-1] &&
                       (in_value_reg[VALUE_W-2:0] < (VALUE_W-1)'(NUM_SLOTS));
    assign cur_pend  = slot_pend_reg[cur_slot_reg];
    assign not_press = (cur_pend != ST_PRESS);
    assign x_next    = scale_pos(in_value_reg, width_reg);
    assign y_next    = scale_pos(in_value_reg, height_reg);
    assign cur_slot_next = in_value_reg[SLOT_IDX_W-1:0];

    always_comb begin
        res_status = ST_NONE;
        res_emit   = 1'b0;
        pend_wr    = 1'b0;
        pend_next  = ST_NONE;
        x_wr       = 1'b0;
        y_wr       = 1'b0;
        slot_wr    = 1'b0;
        if (is_abs) begin
            case (in_code_reg)
                CODE_SLOT: begin
                    if (slot_ok) begin
                        slot_wr = 1'b1;
                        if (cur_pend != ST_NONE) begin
                            res_emit   = 1'b1;
                            res_status = cur_pend;
                            pend_wr    = 1'b1;
                        end
                    end
                end
                CODE_TRACK: begin
                    pend_wr = 1'b1;
                    if (&in_value_reg) begin
                        res_emit   = 1'b1;
                        res_status = ST_RELEASE;
                    end else begin
                        pend_next = ST_PRESS;
                    end
                end
                CODE_X: begin
                    x_wr      = 1'b1;
                    pend_wr   = not_press;
                    pend_next = ST_MOVE;
                end
                CODE_Y: begin
                    y_wr      = 1'b1;
                    pend_wr   = not_press;
                    pend_next = ST_MOVE;
                end
                default: ;
            endcase
        end else if (in_type_reg == TYPE_SYN && in_code_reg == CODE_REPORT) begin
            if (cur_pend != ST_NONE) begin
                res_emit   = 1'b1;
                res_status = cur_pend;
                pend_wr    = 1'b1;
            end
        end
    end

    // slot table and current slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_slot_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_x_reg[i]    <= '0;
                slot_y_reg[i]    <= '0;
                slot_pend_reg[i] <= ST_NONE;
            end
        end else if (advance) begin
            if (slot_wr) begin
                cur_slot_reg <= cur_slot_next;
            end
            if (pend_wr) begin
                slot_pend_reg[cur_slot_reg] <= pend_next;
            end
            if (x_wr) begin
                slot_x_reg[cur_slot_reg] <= x_next;
            end
            if (y_wr) begin
                slot_y_reg[cur_slot_reg] <= y_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_status_reg <= res_status;
            out_x_reg      <= res_emit ? slot_x_reg[cur_slot_reg] : '0;
            out_y_reg      <= res_emit ? slot_y_reg[cur_slot_reg] : '0;
            out_finger_reg <= res_emit ? FINGER_W'(cur_slot_reg) : '0;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mtsed_checker.sv -----
// Port-level checks for the multitouch slot event decoder, bound to its top level.
// Depends on mtsed_pkg for widths, slot count and status codes.
`timescale 1ns / 1ps
`default_nettype none

module mtsed_checker
    import mtsed_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata,
    input wire logic [M_TUSER_W-1:0]  m_tuser
);

    // a word with no report carries no position or finger
    a_none_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_NONE) |-> (m_tdata == '0))
        else $error("report word with status none has nonzero data");

    // the reported finger is always a slot that exists
    a_finger_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2*POS_W+FINGER_W-1:2*POS_W] < FINGER_W'(NUM_SLOTS)))
        else $error("finger outside slot table");

    // no word appears on the master side without an event taken before it
    a_no_word_unasked: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$past(m_tvalid) && !$past(s_tvalid && s_tready, 2)
        && $past(aresetn, 2) |-> !m_tvalid)
        else $error("report word without a preceding event");

    // hold a stalled word
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled report word changed");

endmodule

bind multitouch_slot_event_decoder_unit mtsed_checker u_mtsed_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- tb/multitouch_slot_event_decoder_unit_tb.sv -----
// Self-checking testbench for the multitouch slot event decoder unit.
// Drives event words, predicts every report word and checks them in order.
// Depends on mtsed_pkg and multitouch_slot_event_decoder_unit.
`timescale 1ns / 1ps

module multitouch_slot_event_decoder_unit_tb;
    import mtsed_pkg::*;

    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  ITEMS_PER_SET = 165;
    localparam int  SETTLE_CYCLES = 6;
    localparam logic [VALUE_W-1:0] RELEASE_ID = '1;

    typedef struct packed {
        logic [TYPE_W-1:0]  kind;
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] value;
    } touch_event_t;

    typedef struct packed {
        touch_status_t     status;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [FINGER_W-1:0] finger;
    } touch_report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    multitouch_slot_event_decoder_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Decoder shadow state
    logic [SIZE_W-1:0] shadow_width;
    logic [SIZE_W-1:0] shadow_height;
    logic [POS_W-1:0]  shadow_x [NUM_SLOTS];
    logic [POS_W-1:0]  shadow_y [NUM_SLOTS];
    touch_status_t     shadow_pending [NUM_SLOTS];
    int                shadow_slot;

    touch_event_t  pending_events [$];
    touch_report_t expected_reports [$];
    touch_event_t  driven_event;
    int            mismatch_count = 0;
    int            cycle_count = 0;
    int            queued_count = 0;
    int            checked_count = 0;

    function automatic logic [POS_W-1:0] scaled_position(logic [VALUE_W-1:0] raw,
                                                         logic [SIZE_W-1:0] size);
        longint clamped;
        longint product;
        if (raw[VALUE_W-1]) begin
            clamped = 0;
        end else if (raw > 4095) begin
            clamped = 4095;
        end else begin
            clamped = longint'(raw);
        end
        product = (clamped * longint'(size)) >>> POS_W;
        return (product > 4095) ? '1 : product[POS_W-1:0];
    endfunction

    function automatic touch_report_t finger_report(touch_status_t status, int slot);
        touch_report_t rep;
        rep.status = status;
        rep.x      = shadow_x[slot];
        rep.y      = shadow_y[slot];
        rep.finger = slot[FINGER_W-1:0];
        return rep;
    endfunction

    function automatic void reset_decoder_state();
        shadow_width  = SCREEN_WIDTH_RST;
        shadow_height = SCREEN_HEIGHT_RST;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            shadow_x[i]       = '0;
            shadow_y[i]       = '0;
            shadow_pending[i] = ST_NONE;
        end
        shadow_slot = 0;
    endfunction

    // Apply one event to the shadow slot table and return the report it causes.
    function automatic touch_report_t decode_event(touch_event_t ev);
        touch_report_t rep;
        int cs;
        rep = '{status: ST_NONE, x: '0, y: '0, finger: '0};
        cs  = shadow_slot;
        if (ev.kind == TYPE_ABS) begin
            case (ev.code)
                CODE_SLOT: begin
                    if (!ev.value[VALUE_W-1] && ev.value < NUM_SLOTS) begin
                        shadow_slot = int'(ev.value);
                        if (shadow_pending[cs] != ST_NONE) begin
                            rep = finger_report(shadow_pending[cs], cs);
                            shadow_pending[cs] = ST_NONE;
                        end
                    end
                end
                CODE_TRACK: begin
                    if (ev.value == RELEASE_ID) begin
                        rep = finger_report(ST_RELEASE, cs);
                        shadow_pending[cs] = ST_NONE;
                    end else begin
                        shadow_pending[cs] = ST_PRESS;
                    end
                end
                CODE_X: begin
                    shadow_x[cs] = scaled_position(ev.value, shadow_width);
                    if (shadow_pending[cs] != ST_PRESS) shadow_pending[cs] = ST_MOVE;
                end
                CODE_Y: begin
                    shadow_y[cs] = scaled_position(ev.value, shadow_height);
                    if (shadow_pending[cs] != ST_PRESS) shadow_pending[cs] = ST_MOVE;
                end
                default: ;
            endcase
        end else if (ev.kind == TYPE_SYN && ev.code == CODE_REPORT) begin
            if (shadow_pending[cs] != ST_NONE) begin
                rep = finger_report(shadow_pending[cs], cs);
                shadow_pending[cs] = ST_NONE;
            end
        end
        return rep;
    endfunction

    function automatic void queue_event(logic [TYPE_W-1:0] kind, logic [CODE_W-1:0] code,
                                        logic [VALUE_W-1:0] value);
        touch_event_t ev;
        ev.kind  = kind;
        ev.code  = code;
        ev.value = value;
        pending_events.push_back(ev);
        queued_count++;
    endfunction

    function automatic logic [VALUE_W-1:0] random_position();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) return VALUE_W'($urandom_range(0, 4095));
        if (pick == 7) return ($urandom_range(0, 1) != 0) ? 32'd4095 : 32'd0;
        if (pick == 8) return $urandom;
        return -VALUE_W'($urandom_range(1, 5000));
    endfunction

    // Add well-formed frames with random content, mixed with noise and broken frames.
    task automatic queue_random_frames(int target);
        int count;
        int fingers;
        int slot;
        int action;
        count = 0;
        while (count < target) begin
            if ($urandom_range(0, 99) < 80) begin
                fingers = $urandom_range(1, 3);
                for (int f = 0; f < fingers; f++) begin
                    slot = $urandom_range(0, NUM_SLOTS - 1);
                    if ($urandom_range(0, 9) != 0) begin
                        queue_event(TYPE_ABS, CODE_SLOT, VALUE_W'(slot));
                        count++;
                    end
                    action = $urandom_range(0, 99);
                    if (action < 15) begin
                        queue_event(TYPE_ABS, CODE_TRACK, RELEASE_ID);
                        count++;
                    end else begin
                        if (action < 40) begin
                            queue_event(TYPE_ABS, CODE_TRACK, {1'b0, 31'($urandom)});
                            count++;
                        end
                        if ($urandom_range(0, 3) != 0) begin
                            queue_event(TYPE_ABS, CODE_X, random_position());
                            count++;
                        end
                        if ($urandom_range(0, 3) != 0) begin
                            queue_event(TYPE_ABS, CODE_Y, random_position());
                            count++;
                        end
                    end
                end
                if ($urandom_range(0, 9) != 0) begin
                    queue_event(TYPE_SYN, CODE_REPORT, $urandom);
                    count++;
                end
            end else begin
                case ($urandom_range(0, 4))
                    0: queue_event(TYPE_W'($urandom), CODE_W'($urandom), $urandom);
                    1: queue_event(TYPE_ABS, CODE_SLOT,
                                   ($urandom_range(0, 1) != 0) ? $urandom
                                                               : VALUE_W'($urandom_range(5, 16)));
                    2: queue_event(TYPE_SYN, CODE_W'($urandom), $urandom);
                    3: queue_event(TYPE_ABS, CODE_TRACK, 32'h8000_0000 | $urandom);
                    default: queue_event(TYPE_ABS, CODE_W'($urandom_range(0, 63)), $urandom);
                endcase
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_SCREEN_WIDTH) begin
            shadow_width = value;
        end else begin
            shadow_height = value;
        end
    endtask

    // Hold until every queued word has come back as a checked report word.
    task automatic wait_drained();
        while (checked_count != queued_count)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Sender: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin : event_driver
        logic next_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) expected_reports.push_back(decode_event(driven_event));
            if (!s_tvalid || s_tready) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_events.size() != 0) begin
                    driven_event = pending_events.pop_front();
                    next_valid   = 1'b1;
                    s_tdata <= {driven_event.value, driven_event.code};
                    s_tuser <= driven_event.kind;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
                                                                 : $urandom_range(0, 2);
                    end
                end
                s_tvalid <= next_valid;
            end
        end
    end

    // Receiver: stall pattern switches at random among four modes
    int rx_mode = 0;
    int rx_left = 0;
    int rx_phase = 0;

    always @(posedge aclk) begin : report_monitor
        touch_report_t want;
        logic ready_next;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_reports.size() == 0) begin
                $error("report word with none expected: status=%0d data=%h", m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                want = expected_reports.pop_front();
                checked_count++;
                if (m_tuser != want.status) begin
                    $error("touch_status: expected %0d, actual %0d", want.status, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[11:0] != want.x) begin
                    $error("x_coord: expected %0d, actual %0d", want.x, m_tdata[11:0]);
                    mismatch_count++;
                end
                if (m_tdata[23:12] != want.y) begin
                    $error("y_coord: expected %0d, actual %0d", want.y, m_tdata[23:12]);
                    mismatch_count++;
                end
                if (m_tdata[27:24] != want.finger) begin
                    $error("finger: expected %0d, actual %0d", want.finger, m_tdata[27:24]);
                    mismatch_count++;
                end
                if (m_tdata[31:28] != 4'd0) begin
                    $error("zero fill: expected 0, actual %0d", m_tdata[31:28]);
                    mismatch_count++;
                end
            end
        end
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 300);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            0:       ready_next = 1'b1;
            1:       ready_next = ($urandom_range(0, 3) != 0);
            2:       ready_next = (rx_phase % 4 == 0);
            default: ready_next = ($urandom_range(0, 9) == 0);
        endcase
        m_tready <= ready_next;
    end

    always @(posedge aclk) begin : run_limit
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    logic [SIZE_W-1:0] set_width [7];
    logic [SIZE_W-1:0] set_height [7];

    initial begin
        reset_decoder_state();
        set_width  = '{13'd4096, 13'd1, 13'd0, 13'd8191, 13'd4097, 13'd0, 13'd0};
        set_height = '{13'd4096, 13'd1, 13'd8191, 13'd0, 13'd1, 13'd0, 13'd0};
        for (int i = 5; i < 7; i++) begin
            set_width[i]  = SIZE_W'($urandom_range(1, 4096));
            set_height[i] = SIZE_W'($urandom_range(1, 4096));
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed events under the reset screen size
        queue_event(TYPE_ABS, CODE_X, 32'd4095);
        queue_event(TYPE_ABS, CODE_Y, -32'sd5);
        queue_event(TYPE_SYN, CODE_REPORT, 32'd0);     // move on slot 0
        queue_event(TYPE_SYN, CODE_REPORT, 32'd0);     // nothing pending
        queue_event(TYPE_ABS, CODE_TRACK, 32'd7);
        queue_event(TYPE_ABS, CODE_X, 32'h7fff_ffff);
        queue_event(TYPE_ABS, CODE_Y, 32'd2048);
        queue_event(TYPE_SYN, CODE_REPORT, 32'hffff_ffff);
        queue_event(TYPE_ABS, CODE_SLOT, 32'd2);
        queue_event(TYPE_ABS, CODE_TRACK, 32'd0);
        queue_event(TYPE_ABS, CODE_X, 32'd100);
        queue_event(TYPE_ABS, CODE_SLOT, 32'd2);       // same slot still flushes
        queue_event(TYPE_ABS, CODE_SLOT, 32'd5);       // out of range
        queue_event(TYPE_ABS, CODE_SLOT, 32'hffff_ffff);
        queue_event(TYPE_ABS, CODE_SLOT, 32'h8000_0000);
        queue_event(TYPE_ABS, CODE_TRACK, RELEASE_ID);
        queue_event(TYPE_ABS, CODE_SLOT, 32'd4);
        queue_event(TYPE_ABS, CODE_Y, 32'd4096);
        queue_event(TYPE_ABS, CODE_SLOT, 32'd0);       // flush move of slot 4
        queue_event(TYPE_ABS, CODE_TRACK, RELEASE_ID);
        queue_event(16'hffff, 16'hffff, 32'd0);
        queue_event(16'h0001, CODE_X, 32'd10);
        queue_event(TYPE_SYN, 16'h0001, 32'd0);
        queue_event(TYPE_ABS, CODE_REPORT, 32'd3);
        queue_event(16'h8003, CODE_X, 32'd10);
        wait_drained();

        for (int p = 0; p < 7; p++) begin
            write_reg(CFG_SCREEN_WIDTH, set_width[p]);
            write_reg(CFG_SCREEN_HEIGHT, set_height[p]);
            queue_random_frames(ITEMS_PER_SET);
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
